// ===== src/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg: shared types and constants of the page frame allocator
// Command codes, controller states, and the control and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int WORD_BITS   = 8;
	localparam int BASE_FRAMES = 256;
	localparam int BASE_WORDS  = BASE_FRAMES / WORD_BITS;
	// frame arithmetic is done at this width (frame numbers reach 2^20)
	localparam int LW = 22;
	localparam logic [LW-1:0] POOL_BASE_FRAME = LW'(BASE_FRAMES);
	localparam logic [LW-1:0] LIMIT_FRAME     = 22'h0FFFF0;

	typedef enum logic [1:0] {
		CMD_ALLOC_ONE = 2'd0,
		CMD_ALLOC_RUN = 2'd1,
		CMD_FREE_ONE  = 2'd2,
		CMD_FREE_RUN  = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_CHECK,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic load_cfg;
		logic scan_init;
		logic scan_run;
		logic rmw_init_alloc;
		logic rmw_init_free;
		logic rmw_init_cfg;
		logic rmw_wr;
		logic set_fail;
		logic set_free_ok;
		logic set_alloc_ok;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic bad_n;
		logic free_empty;
		logic cfg_empty;
		logic scan_found;
		logic scan_miss;
		logic limit_exc;
		logic rmw_last;
		logic out_free;
	} stat_t;

endpackage

// ===== src/page_frame_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_unit: bitmap allocator of 4 KiB physical frames
// Allocates and frees single frames or runs in a base map below 1 MiB and a
// pool map above it.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis: one command per transaction. tuser = cmd, use_pool; tdata =
//    phys_address, frame_count. m_axis: one result per command, tdata =
//    frame_address, success.
//  - cfg: writes the usable pool size (frames). Taken while the block is idle
//    or clearing; entries at or above the new size are swept to used, word by
//    word with a read and a write per 8-frame word, up to the end of the pool.
//  - After reset both maps are swept to all used, word by word over
//    max(POOL_FRAMES/8, 32) words, with s_axis_tready low.
//  - Allocation scans the chosen map at 8 frames per cycle, stopping early
//    when a free run is found (scan loop and the single read port of each map
//    bound this), then marks the run used with a read and a write per word.
//    Frees clear each word touched with a read and a write.
//  - One command at a time. The result register frees the input side: a new
//    command is taken while a result waits; a stalled m_axis only holds the
//    block once a second result is ready.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_unit #(
	parameter int POOL_FRAMES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [31:0] phys_address, [44:32] frame_count
	input  logic [2:0]  s_axis_tuser,  // [1:0] cmd, [2] use_pool
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] frame_address, [32] success
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data       // pool_frames_in_use
);
	import pfba_pkg::*;

	ctrl_t       ctrl;
	stat_t       stat;
	logic [31:0] out_addr;
	logic        out_ok;

	// sequencer
	pfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// maps, scan and result register
	pfba_datapath #(
		.POOL_FRAMES (POOL_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_addr  (out_addr),
		.out_ok    (out_ok)
	);

	assign m_axis_tdata = {7'd0, out_ok, out_addr};

	// a taken command closes the input side on the next cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken right after a command");

	// a config write never overlaps a command
	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !s_axis_tready)
		else $error("input open during a config write");

	// failed allocations carry address zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("failure with nonzero address");

	// result register only loads in a free slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("pending result overwritten");

endmodule

// ===== src/pfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfba_ctrl: sequencer of the page frame allocator
// Walks clear, scan, limit check and read-modify-write phases.
// ----------------------------------------------------------------------------
module pfba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  pfba_pkg::stat_t stat,
	output pfba_pkg::ctrl_t ctrl
);
	import pfba_pkg::*;

	state_t state_q, state_d;
	logic   rmw_cfg_q, rmw_cfg_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			rmw_cfg_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rmw_cfg_q <= rmw_cfg_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rmw_cfg_d = rmw_cfg_q;
		ctrl      = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cfg_ready     = 1'b1;
				ctrl.clr_step = 1'b1;
				ctrl.load_cfg = cfg_valid;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				if (cfg_valid) begin
					ctrl.load_cfg = 1'b1;
					if (!stat.cfg_empty) begin
						ctrl.rmw_init_cfg = 1'b1;
						rmw_cfg_d         = 1'b1;
						state_d           = ST_RMW_RD;
					end
				end else if (in_valid) begin
					ctrl.load_item = 1'b1;
					rmw_cfg_d      = 1'b0;
					state_d        = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (stat.is_alloc) begin
					if (stat.bad_n) begin
						ctrl.set_fail = 1'b1;
						state_d       = ST_DONE;
					end else begin
						ctrl.scan_init = 1'b1;
						state_d        = ST_SCAN;
					end
				end else begin
					ctrl.set_free_ok = 1'b1;
					if (stat.free_empty) begin
						state_d = ST_DONE;
					end else begin
						ctrl.rmw_init_free = 1'b1;
						state_d            = ST_RMW_RD;
					end
				end
			end
			ST_SCAN: begin
				ctrl.scan_run = 1'b1;
				if (stat.scan_found) begin
					state_d = ST_CHECK;
				end else if (stat.scan_miss) begin
					ctrl.set_fail = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_CHECK: begin
				if (stat.limit_exc) begin
					ctrl.set_fail = 1'b1;
					state_d       = ST_DONE;
				end else begin
					ctrl.set_alloc_ok   = 1'b1;
					ctrl.rmw_init_alloc = 1'b1;
					state_d             = ST_RMW_RD;
				end
			end
			ST_RMW_RD: begin
				state_d = ST_RMW_WR;
			end
			ST_RMW_WR: begin
				ctrl.rmw_wr = 1'b1;
				if (stat.rmw_last) state_d = rmw_cfg_q ? ST_IDLE : ST_DONE;
				else               state_d = ST_RMW_RD;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/pfba_datapath.sv =====
// ----------------------------------------------------------------------------
// pfba_datapath: bitmap memories, scan unit and result register
// Maps are stored 8 frames per word; 1 marks a used frame.
// ----------------------------------------------------------------------------
module pfba_datapath #(
	parameter int POOL_FRAMES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pfba_pkg::ctrl_t ctrl,
	output pfba_pkg::stat_t stat,
	input  logic [47:0]     in_data,
	input  logic [2:0]      in_user,
	input  logic [12:0]     cfg_data,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [31:0]     out_addr,
	output logic            out_ok
);
	import pfba_pkg::*;

	localparam int PW  = (POOL_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int PWA = (PW > 1) ? $clog2(PW) : 1;
	localparam int WA  = (PWA > 5) ? PWA : 5;
	localparam int CW  = (PW > BASE_WORDS) ? PW : BASE_WORDS;
	localparam int CWA = $clog2(CW);
	localparam int IWR = $clog2(PW * WORD_BITS + 1);
	localparam int IW  = (IWR > 9) ? IWR : 9;
	localparam logic [LW-1:0] POOL_SPAN = LW'(PW * WORD_BITS);
	localparam logic [LW-1:0] POOL_MAX  = LW'(POOL_FRAMES);

	logic [WORD_BITS-1:0] pool_mem [PW];
	logic [WORD_BITS-1:0] base_mem [BASE_WORDS];
	logic [WORD_BITS-1:0] pool_rd_q, base_rd_q;

	logic [IW-1:0]  size_q;
	logic [CWA-1:0] clr_q;
	cmd_e_t         cmd_q;
	logic           pool_q;
	logic [19:0]    addr_q;
	logic [12:0]    n_q;
	logic [WA-1:0]  scan_q, rvw_s1;
	logic           rvld_s1;
	logic [12:0]    run_q;
	logic [IW-1:0]  start_q;
	logic [IW-1:0]  rlo_q, rhi_q;
	logic           rval_q, rmap_q;
	logic [WA-1:0]  rw_q;
	logic           res_ok_q, out_valid_q, out_ok_q;
	logic [31:0]    res_addr_q, out_addr_q;

	logic [LW-1:0] size_eff, last_word, n_w, start_w;
	logic [LW-1:0] lo_f, hi_f, lim_f, sum_f, cfg_size, frame_w, end_w;
	logic          is_base;
	logic [WA-1:0] rd_addr;
	logic [12:0]   run_v;
	logic          fnd;
	logic [LW-1:0] st_v;
	logic [WORD_BITS-1:0] sd, rd, wmask, wdata;

	assign n_w      = LW'(n_q);
	assign start_w  = LW'(start_q);
	assign size_eff = pool_q ? LW'(size_q) : POOL_BASE_FRAME;
	assign last_word = (size_eff - LW'(1)) >> 3;

	// free range, clipped to the selected map
	assign is_base = (addr_q[19:8] == 12'd0);
	assign lo_f    = is_base ? LW'(addr_q) : (LW'(addr_q) - POOL_BASE_FRAME);
	assign lim_f   = is_base ? POOL_BASE_FRAME : LW'(size_q);
	assign sum_f   = lo_f + n_w;
	assign hi_f    = (sum_f > lim_f) ? lim_f : sum_f;

	assign cfg_size = (LW'(cfg_data) > POOL_MAX) ? POOL_MAX : LW'(cfg_data);

	assign frame_w = (pool_q ? POOL_BASE_FRAME : LW'(0)) + start_w;
	assign end_w   = frame_w + n_w;

	assign rd_addr = ctrl.scan_run ? scan_q : rw_q;

	// scan of one word, bit by bit, carrying the run length across words
	always_comb begin
		logic [LW-1:0] idx;
		logic          used;
		sd    = pool_q ? pool_rd_q : base_rd_q;
		run_v = run_q;
		fnd   = 1'b0;
		st_v  = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			idx  = (LW'(rvw_s1) << 3) + LW'(j);
			used = sd[j] || (idx >= size_eff);
			if (!fnd) begin
				if (used) begin
					run_v = '0;
				end else begin
					run_v = run_v + 13'd1;
					if (run_v == n_q) begin
						fnd  = 1'b1;
						st_v = idx + LW'(1) - n_w;
					end
				end
			end
		end
	end

	// read-modify-write word
	always_comb begin
		logic [LW-1:0] idx;
		rd = rmap_q ? pool_rd_q : base_rd_q;
		for (int j = 0; j < WORD_BITS; j++) begin
			idx      = (LW'(rw_q) << 3) + LW'(j);
			wmask[j] = (idx >= LW'(rlo_q)) && (idx < LW'(rhi_q));
		end
		wdata = rval_q ? (rd | wmask) : (rd & ~wmask);
	end

	always_comb begin
		stat            = '0;
		stat.clr_last   = (clr_q == CWA'(CW - 1));
		stat.is_alloc   = (cmd_q == CMD_ALLOC_ONE) || (cmd_q == CMD_ALLOC_RUN);
		stat.bad_n      = (n_q == 13'd0) || (n_w > size_eff);
		stat.free_empty = (lo_f >= hi_f);
		stat.cfg_empty  = (cfg_size >= POOL_SPAN);
		stat.scan_found = rvld_s1 && fnd;
		stat.scan_miss  = rvld_s1 && !fnd && (LW'(rvw_s1) == last_word);
		stat.limit_exc  = (end_w > LIMIT_FRAME);
		stat.rmw_last   = (LW'(rw_q) == ((LW'(rhi_q) - LW'(1)) >> 3));
		stat.out_free   = !out_valid_q || out_ready;
	end

	// memories
	always_ff @(posedge clk) begin
		if (ctrl.clr_step) begin
			if ({1'b0, clr_q} < (CWA+1)'(PW)) pool_mem[clr_q[PWA-1:0]] <= '1;
			if ({1'b0, clr_q} < (CWA+1)'(BASE_WORDS)) base_mem[clr_q[4:0]] <= '1;
		end else if (ctrl.rmw_wr) begin
			if (rmap_q) pool_mem[rw_q[PWA-1:0]] <= wdata;
			else        base_mem[rw_q[4:0]]     <= wdata;
		end
		pool_rd_q <= pool_mem[rd_addr[PWA-1:0]];
		base_rd_q <= base_mem[rd_addr[4:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			clr_q       <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_cfg) size_q <= cfg_size[IW-1:0];
			if (ctrl.clr_step && !stat.clr_last) clr_q <= clr_q + CWA'(1);
			rvld_s1 <= ctrl.scan_run;
			if (ctrl.out_load)   out_valid_q <= 1'b1;
			else if (out_ready)  out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			cmd_q  <= cmd_e_t'(in_user[1:0]);
			pool_q <= in_user[2];
			addr_q <= in_data[31:12];
			if ((cmd_e_t'(in_user[1:0]) == CMD_ALLOC_ONE) ||
			    (cmd_e_t'(in_user[1:0]) == CMD_FREE_ONE))
				n_q <= 13'd1;
			else
				n_q <= in_data[44:32];
		end
		if (ctrl.scan_init) begin
			scan_q <= '0;
			run_q  <= '0;
		end else if (ctrl.scan_run) begin
			scan_q <= scan_q + WA'(1);
			if (rvld_s1) run_q <= run_v;
		end
		rvw_s1 <= scan_q;
		if (ctrl.scan_run && rvld_s1 && fnd) start_q <= st_v[IW-1:0];

		if (ctrl.rmw_init_cfg) begin
			rlo_q  <= cfg_size[IW-1:0];
			rhi_q  <= POOL_SPAN[IW-1:0];
			rval_q <= 1'b1;
			rmap_q <= 1'b1;
			rw_q   <= WA'(cfg_size >> 3);
		end else if (ctrl.rmw_init_alloc) begin
			rlo_q  <= start_q;
			rhi_q  <= IW'(start_w + n_w);
			rval_q <= 1'b1;
			rmap_q <= pool_q;
			rw_q   <= WA'(start_w >> 3);
		end else if (ctrl.rmw_init_free) begin
			rlo_q  <= lo_f[IW-1:0];
			rhi_q  <= hi_f[IW-1:0];
			rval_q <= 1'b0;
			rmap_q <= !is_base;
			rw_q   <= WA'(lo_f >> 3);
		end else if (ctrl.rmw_wr) begin
			rw_q <= rw_q + WA'(1);
		end

		if (ctrl.set_fail) begin
			res_ok_q   <= 1'b0;
			res_addr_q <= '0;
		end else if (ctrl.set_free_ok) begin
			res_ok_q   <= 1'b1;
			res_addr_q <= '0;
		end else if (ctrl.set_alloc_ok) begin
			res_ok_q   <= 1'b1;
			res_addr_q <= {frame_w[19:0], 12'h000};
		end
		if (ctrl.out_load) begin
			out_ok_q   <= res_ok_q;
			out_addr_q <= res_addr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_addr  = out_addr_q;
	assign out_ok    = out_ok_q;

endmodule

// ===== test/page_frame_bitmap_allocator_unit_test.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_unit_test: self-checking bench of the allocator
// Streams alloc/free commands through s_axis, predicts every result from a
// private copy of both used maps, and compares it with m_axis in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_unit_test;
	import pfba_pkg::*;

	localparam int POOL_N = 4096;
	localparam int BASE_N = 256;
	localparam logic [63:0] FRAME_SZ  = 64'h1000;
	localparam logic [63:0] POOL_ADDR = 64'h100000;
	localparam logic [63:0] TOP_ADDR  = 64'hFFFF0000;

	typedef struct packed {
		cmd_e_t      cmd;
		logic        use_pool;
		logic [31:0] phys_address;
		logic [12:0] frame_count;
	} command_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic        success;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [12:0] cfg_data = '0;

	page_frame_bitmap_allocator_unit dut (.*);

	// predictor state
	logic base_used [BASE_N];
	logic pool_used [POOL_N];
	int unsigned pool_frames;

	command_t pending_cmds[$];
	outcome_t awaited[$];
	int failures = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// lowest start of n free frames below size; -1 if none
	function automatic int first_free_run(bit pool, int unsigned size, int unsigned n);
		int unsigned run;
		bit used;
		run = 0;
		if (n == 0 || n > size) return -1;
		for (int unsigned i = 0; i < size; i++) begin
			used = pool ? pool_used[i] : base_used[i];
			if (used) run = 0;
			else begin
				run++;
				if (run == n) return int'(i + 1 - n);
			end
		end
		return -1;
	endfunction

	function automatic void mark_frames(bit pool, longint unsigned start, longint unsigned n,
			logic v);
		longint unsigned size;
		size = pool ? pool_frames : BASE_N;
		for (longint unsigned i = 0; i < n; i++) begin
			if (start + i >= size) break;
			if (pool) pool_used[start + i] = v;
			else base_used[start + i] = v;
		end
	endfunction

	function automatic outcome_t serve_command(command_t c);
		outcome_t r;
		int s;
		longint unsigned n, a;
		r = '0;
		if (c.cmd == CMD_ALLOC_ONE || c.cmd == CMD_ALLOC_RUN) begin
			n = (c.cmd == CMD_ALLOC_ONE) ? 1 : c.frame_count;
			s = first_free_run(c.use_pool, c.use_pool ? pool_frames : BASE_N, 32'(n));
			if (s >= 0) begin
				a = (c.use_pool ? POOL_ADDR : 0) + longint'(s) * FRAME_SZ;
				// over the limit: the frames stay free and the alloc fails
				if (a + n * FRAME_SZ <= TOP_ADDR) begin
					mark_frames(c.use_pool, s, n, 1'b1);
					r.frame_address = a[31:0];
					r.success = 1'b1;
				end
			end
		end else begin
			n = (c.cmd == CMD_FREE_ONE) ? 1 : c.frame_count;
			a = c.phys_address;
			if (a < POOL_ADDR) mark_frames(1'b0, a / FRAME_SZ, n, 1'b0);
			else mark_frames(1'b1, (a - POOL_ADDR) / FRAME_SZ, n, 1'b0);
			r.success = 1'b1;
		end
		return r;
	endfunction

	function automatic void apply_pool_size(logic [12:0] v);
		pool_frames = (v > POOL_N) ? POOL_N : v;
		for (int i = pool_frames; i < POOL_N; i++) pool_used[i] = 1'b1;
	endfunction

	initial begin
		forever #2 clk = ~clk;
	end

	// driver: pops one transaction at a time, holds it until accepted
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			command_t c;
			c = pending_cmds.pop_front();
			awaited.push_back(serve_command(c));
		end
		// the queue head is the next transaction to drive
		if ((!s_axis_tvalid || s_axis_tready) && arst_n) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b0, pending_cmds[0].frame_count,
					pending_cmds[0].phys_address};
				s_axis_tuser <= {pending_cmds[0].use_pool, pending_cmds[0].cmd};
			end else s_axis_tvalid <= 1'b0;
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (m_axis_tvalid && m_axis_tready) begin
			if (awaited.size() == 0) begin
				failures++;
				$display("%t unexpected result %h", $realtime, m_axis_tdata);
			end else begin
				outcome_t e;
				e = awaited.pop_front();
				if (m_axis_tdata[31:0] !== e.frame_address) begin
					failures++;
					$display("%t frame_address expected %h actual %h", $realtime,
						e.frame_address, m_axis_tdata[31:0]);
				end
				if (m_axis_tdata[32] !== e.success) begin
					failures++;
					$display("%t success expected %b actual %b", $realtime,
						e.success, m_axis_tdata[32]);
				end
			end
		end
	end

	task automatic queue_cmd(cmd_e_t c, logic p, logic [31:0] a, logic [12:0] n);
		command_t x;
		x.cmd = c; x.use_pool = p; x.phys_address = a; x.frame_count = n;
		pending_cmds.push_back(x);
	endtask

	task automatic drain_all();
		while (pending_cmds.size() != 0 || s_axis_tvalid || awaited.size() != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_pool_size(logic [12:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_pool_size(v);
	endtask

	// mixed traffic: allocs and frees interleaved, frees mostly inside the maps, random sizes
	task automatic random_phase(int items);
		int k;
		logic [31:0] a;
		for (int i = 0; i < items; i++) begin
			k = $urandom_range(99);
			if (k < 30)
				queue_cmd(CMD_ALLOC_ONE, 1'($urandom_range(1)), $urandom, 13'($urandom));
			else if (k < 50)
				queue_cmd(CMD_ALLOC_RUN, 1'($urandom_range(1)), $urandom,
					($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 24)));
			else begin
				case ($urandom_range(3))
					0: a = $urandom_range(BASE_N - 1) * 4096 + $urandom_range(4095);
					1, 2: a = 32'h100000 + $urandom_range(POOL_N + 8) * 4096
						+ $urandom_range(4095);
					default: a = $urandom;
				endcase
				if (k < 70)
					queue_cmd(CMD_FREE_ONE, 1'($urandom_range(1)), a, 13'($urandom));
				else
					queue_cmd(CMD_FREE_RUN, 1'($urandom_range(1)), a,
						($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40)));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < BASE_N; i++) base_used[i] = 1'b1;
		for (int i = 0; i < POOL_N; i++) pool_used[i] = 1'b1;
		pool_frames = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, maps all used: allocs miss until a base frame is freed
		send_idle_pct = 7; recv_idle_pct = 63;
		queue_cmd(CMD_ALLOC_ONE, 1'b1, 32'h0, 13'd1);
		queue_cmd(CMD_ALLOC_ONE, 1'b0, 32'hFFFFFFFF, 13'h1FFF);
		queue_cmd(CMD_ALLOC_RUN, 1'b0, 32'h0, 13'd0);
		queue_cmd(CMD_FREE_RUN, 1'b1, 32'h0, 13'd0);
		queue_cmd(CMD_FREE_RUN, 1'b1, 32'h0, 13'd256);
		queue_cmd(CMD_ALLOC_RUN, 1'b0, 32'h0, 13'd256);
		queue_cmd(CMD_ALLOC_RUN, 1'b0, 32'h0, 13'd257);
		queue_cmd(CMD_FREE_ONE, 1'b0, 32'h000FFFFF, 13'd0);
		queue_cmd(CMD_ALLOC_ONE, 1'b0, 32'h0, 13'd0);
		queue_cmd(CMD_FREE_RUN, 1'b0, 32'h000F0ABC, 13'd40);   // run crosses into pool
		queue_cmd(CMD_FREE_RUN, 1'b0, 32'h00100000, 13'h1FFF); // empty pool: ignored
		queue_cmd(CMD_ALLOC_ONE, 1'b1, 32'h0, 13'd0);
		drain_all();

		write_pool_size(13'd4096);
		queue_cmd(CMD_FREE_RUN, 1'b0, 32'h00100000, 13'd4096);
		queue_cmd(CMD_ALLOC_RUN, 1'b1, 32'h0, 13'd4096);
		queue_cmd(CMD_ALLOC_RUN, 1'b1, 32'h0, 13'd4097);
		queue_cmd(CMD_FREE_ONE, 1'b1, 32'hFFFFFFFF, 13'd5);
		queue_cmd(CMD_FREE_ONE, 1'b0, 32'h00100000 + 32'd4095 * 4096, 13'd0);
		queue_cmd(CMD_ALLOC_ONE, 1'b1, 32'h0, 13'd0);
		queue_cmd(CMD_FREE_RUN, 1'b1, 32'h00100000, 13'd4096);
		random_phase(450);
		drain_all();

		// oversize register value clamps to the full pool
		write_pool_size(13'h1FFF);
		send_idle_pct = 63; recv_idle_pct = 7;
		queue_cmd(CMD_FREE_RUN, 1'b0, 32'h00100000, 13'h1FFF);
		queue_cmd(CMD_ALLOC_RUN, 1'b1, 32'h0, 13'h1FFF);
		random_phase(450);
		drain_all();

		write_pool_size(13'd37);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(250);
		drain_all();
		write_pool_size(13'd0);
		random_phase(100);
		drain_all();
		write_pool_size(13'd1);
		random_phase(100);
		drain_all();

		if (failures == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
